FILE: rtl/pl0ts_pkg.sv
// Shared types, constants and lookup functions for the PL/0 token scanner.
// No dependencies; every other file of the scanner imports this package.
`timescale 1ns / 1ps

package pl0ts_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_OFFSET_BITS   = 32;
    localparam int DEF_LENGTH_BITS   = 8;
    localparam int DEF_KEYWORD_CHARS = 9;

    // Result queue sizing: one byte produces at most three tokens
    localparam int RESULTS_MAX = 3;
    localparam int SLOT_COUNT  = 4;
    localparam int QUEUE_DEPTH = 4;

    // Keyword table shape
    localparam int KW_COUNT   = 11;
    localparam int KW_MAX_LEN = 9;

    typedef enum logic [5:0] {
        KIND_IDENT   = 6'd0,
        KIND_NUMBER  = 6'd1,
        KIND_SEMI    = 6'd2,
        KIND_COMMA   = 6'd3,
        KIND_LPAREN  = 6'd4,
        KIND_RPAREN  = 6'd5,
        KIND_TIMES   = 6'd6,
        KIND_SLASH   = 6'd7,
        KIND_PLUS    = 6'd8,
        KIND_MINUS   = 6'd9,
        KIND_EQL     = 6'd10,
        KIND_NEQ     = 6'd11,
        KIND_QUERY   = 6'd12,
        KIND_BANG    = 6'd13,
        KIND_PERIOD  = 6'd14,
        KIND_LSS     = 6'd15,
        KIND_LEQ     = 6'd16,
        KIND_GTR     = 6'd17,
        KIND_GEQ     = 6'd18,
        KIND_BECOMES = 6'd19,
        KIND_BEGIN   = 6'd20,
        KIND_CALL    = 6'd21,
        KIND_CONST   = 6'd22,
        KIND_DO      = 6'd23,
        KIND_ENDKW   = 6'd24,
        KIND_IF      = 6'd25,
        KIND_ODD     = 6'd26,
        KIND_PROC    = 6'd27,
        KIND_THEN    = 6'd28,
        KIND_VAR     = 6'd29,
        KIND_WHILE   = 6'd30,
        KIND_ERROR   = 6'd31,
        KIND_EOF     = 6'd32
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_LT     = 3'd3,
        MODE_GT     = 3'd4,
        MODE_COLON  = 3'd5
    } t_mode;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_sym_hit;

    // First bytes of a pending identifier, index 0 is the first character
    typedef logic [KW_MAX_LEN-1:0][7:0] t_kw_pfx;

    // Character codes
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_TIMES  = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_HASH   = "#";
    localparam logic [7:0] CH_QUERY  = "?";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_PERIOD = ".";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_0      = "0";
    localparam logic [7:0] CH_9      = "9";
    localparam logic [7:0] CH_LO_A   = "a";
    localparam logic [7:0] CH_LO_Z   = "z";
    localparam logic [7:0] CH_UP_A   = "A";
    localparam logic [7:0] CH_UP_Z   = "Z";

    // Keyword text, left-justified and space padded; only the first
    // KW_LEN characters of each entry are compared
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "begin    ", "call     ", "const    ", "do       ",
        "end      ", "if       ", "odd      ", "procedure",
        "then     ", "var      ", "while    "
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd4, 4'd5, 4'd2, 4'd3, 4'd2, 4'd3, 4'd9, 4'd4, 4'd3, 4'd5
    };

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
    endfunction

    // Map a byte to its single-character symbol kind
    function automatic t_sym_hit sym_lookup(input logic [7:0] c);
        t_sym_hit r;
        r.hit  = 1'b1;
        r.kind = KIND_IDENT;
        case (c)
            CH_SEMI:   r.kind = KIND_SEMI;
            CH_COMMA:  r.kind = KIND_COMMA;
            CH_LPAREN: r.kind = KIND_LPAREN;
            CH_RPAREN: r.kind = KIND_RPAREN;
            CH_TIMES:  r.kind = KIND_TIMES;
            CH_SLASH:  r.kind = KIND_SLASH;
            CH_PLUS:   r.kind = KIND_PLUS;
            CH_MINUS:  r.kind = KIND_MINUS;
            CH_EQ:     r.kind = KIND_EQL;
            CH_HASH:   r.kind = KIND_NEQ;
            CH_QUERY:  r.kind = KIND_QUERY;
            CH_BANG:   r.kind = KIND_BANG;
            CH_PERIOD: r.kind = KIND_PERIOD;
            default:   r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // Classify an identifier; len is zero when the identifier is too long
    function automatic t_kind kw_lookup(input t_kw_pfx pfx, input logic [3:0] len);
        t_kind kind;
        logic  match;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            match = (len == KW_LEN[k]);
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if ((4'(i) < KW_LEN[k]) &&
                    (pfx[i] != KW_TEXT[k][(KW_MAX_LEN-1-i)*8 +: 8])) begin
                    match = 1'b0;
                end
            end
            if (match) begin
                kind = t_kind'(6'(KIND_BEGIN) + 6'(k));
            end
        end
        return kind;
    endfunction

endpackage

FILE: rtl/pl0ts_in_if.sv
// Source byte channel of the PL/0 token scanner: valid/ready plus payload.
// Depends on pl0ts_pkg.
`timescale 1ns / 1ps

interface pl0ts_in_if import pl0ts_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

FILE: rtl/pl0ts_out_if.sv
// Token channel of the PL/0 token scanner: valid/ready plus token payload.
// Depends on pl0ts_pkg for the default field widths.
`timescale 1ns / 1ps

interface pl0ts_out_if import pl0ts_pkg::*; #(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) ();
    logic                   valid;
    logic                   ready;
    logic [5:0]             token_kind;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input last_of_run, output ready);
endinterface

FILE: rtl/pl0_token_scanner.sv
// PL/0 token scanner top level: byte-at-a-time lexer with a small token queue.
// Depends on pl0ts_pkg, pl0ts_in_if and pl0ts_out_if.
//
//   channel  | direction | payload
//   ---------+-----------+----------------------------------------------------
//   i_in     | sink      | char_code[7:0], is_last
//   o_out    | source    | token_kind[5:0], start_offset, token_length,
//            |           | last_of_run
//
// One byte per cycle while the input is ready; its zero to three tokens enter a
// four-entry queue at the same edge and leave one per cycle while o_out is ready.
// Input is ready while the queue holds at most one token: a byte that yields two
// or three tokens holds the input while the queue drains.
// i_rst_n is synchronous: it clears the scan mode, offsets and the queue.
// Output stalls never touch the scan state; they hold the queue and the input.
`timescale 1ns / 1ps

module pl0_token_scanner import pl0ts_pkg::*; #(
    parameter int OFFSET_BITS   = DEF_OFFSET_BITS,
    parameter int LENGTH_BITS   = DEF_LENGTH_BITS,
    parameter int KEYWORD_CHARS = DEF_KEYWORD_CHARS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pl0ts_in_if.sink    i_in,
    pl0ts_out_if.source o_out
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W = $clog2(RESULTS_MAX + 1);

    // Scan state
    t_mode                  r_mode,   n_mode;
    logic [OFFSET_BITS-1:0] r_pstart, n_pstart;
    logic [LENGTH_BITS-1:0] r_plen,   n_plen;
    logic [OFFSET_BITS-1:0] r_off,    n_off;
    logic [7:0]             r_prefix [KEYWORD_CHARS];
    logic [7:0]             n_prefix [KEYWORD_CHARS];

    // Token queue, entry 0 is the head
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    t_kind                  r_q_kind  [QUEUE_DEPTH];
    t_kind                  n_q_kind  [QUEUE_DEPTH];
    logic [OFFSET_BITS-1:0] r_q_start [QUEUE_DEPTH];
    logic [OFFSET_BITS-1:0] n_q_start [QUEUE_DEPTH];
    logic [LENGTH_BITS-1:0] r_q_len   [QUEUE_DEPTH];
    logic [LENGTH_BITS-1:0] n_q_len   [QUEUE_DEPTH];
    logic                   r_q_last  [QUEUE_DEPTH];
    logic                   n_q_last  [QUEUE_DEPTH];

    // Step intermediates
    logic [7:0]             c;
    t_sym_hit               sym;
    t_mode                  m_mode;
    logic [OFFSET_BITS-1:0] m_pstart;
    logic [LENGTH_BITS-1:0] m_plen;
    logic                   do_start;
    t_kw_pfx                pfx_cur, pfx_nxt;
    logic [3:0]             len_cur, len_mid;

    // Candidate tokens in emission order: ended token, symbol, flush, end
    logic                   s_vld   [SLOT_COUNT];
    t_kind                  s_kind  [SLOT_COUNT];
    logic [OFFSET_BITS-1:0] s_start [SLOT_COUNT];
    logic [LENGTH_BITS-1:0] s_len   [SLOT_COUNT];

    // Packed tokens of this byte
    logic [RES_W-1:0]       nres;
    t_kind                  res_kind  [RESULTS_MAX];
    logic [OFFSET_BITS-1:0] res_start [RESULTS_MAX];
    logic [LENGTH_BITS-1:0] res_len   [RESULTS_MAX];

    logic                   acc, pop;
    logic [CNT_W-1:0]       base;

    assign c   = i_in.char_code;
    assign sym = sym_lookup(c);

    // Keyword compare inputs before this byte's prefix write
    always_comb begin
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            pfx_cur[i] = r_prefix[i];
        end
        len_cur = (r_plen <= LENGTH_BITS'(KW_MAX_LEN)) ? r_plen[3:0] : 4'd0;
    end

    // Advance the scan by one byte and collect the tokens it ends
    always_comb begin
        m_mode   = r_mode;
        m_pstart = r_pstart;
        m_plen   = r_plen;
        do_start = 1'b0;
        for (int i = 0; i < KEYWORD_CHARS; i++) begin
            n_prefix[i] = r_prefix[i];
        end
        for (int s = 0; s < SLOT_COUNT; s++) begin
            s_vld[s]   = 1'b0;
            s_kind[s]  = KIND_IDENT;
            s_start[s] = r_pstart;
            s_len[s]   = r_plen;
        end

        case (r_mode)
            MODE_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    for (int i = 0; i < KEYWORD_CHARS; i++) begin
                        if (r_plen == LENGTH_BITS'(i)) begin
                            n_prefix[i] = c;
                        end
                    end
                    if (r_plen != '1) begin
                        m_plen = r_plen + 1'b1;
                    end
                end else begin
                    s_vld[0]  = 1'b1;
                    s_kind[0] = kw_lookup(pfx_cur, len_cur);
                    do_start  = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(c)) begin
                    if (r_plen != '1) begin
                        m_plen = r_plen + 1'b1;
                    end
                end else begin
                    s_vld[0]  = 1'b1;
                    s_kind[0] = KIND_NUMBER;
                    do_start  = 1'b1;
                end
            end
            MODE_LT, MODE_GT, MODE_COLON: begin
                s_vld[0] = 1'b1;
                if (c == CH_EQ) begin
                    s_kind[0] = (r_mode == MODE_LT) ? KIND_LEQ :
                                (r_mode == MODE_GT) ? KIND_GEQ : KIND_BECOMES;
                    s_len[0]  = LENGTH_BITS'(2);
                    m_mode    = MODE_IDLE;
                end else begin
                    s_kind[0] = (r_mode == MODE_LT) ? KIND_LSS :
                                (r_mode == MODE_GT) ? KIND_GTR : KIND_ERROR;
                    s_len[0]  = LENGTH_BITS'(1);
                    do_start  = 1'b1;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        // Open a new token when idle or on the byte that ended the old one
        if (do_start) begin
            m_mode = MODE_IDLE;
            if (sym.hit) begin
                s_vld[1]   = 1'b1;
                s_kind[1]  = sym.kind;
                s_start[1] = r_off;
                s_len[1]   = LENGTH_BITS'(1);
            end else begin
                m_pstart = r_off;
                m_plen   = LENGTH_BITS'(1);
                if (c == CH_LT) begin
                    m_mode = MODE_LT;
                end else if (c == CH_GT) begin
                    m_mode = MODE_GT;
                end else if (c == CH_COLON) begin
                    m_mode = MODE_COLON;
                end else if (is_digit(c)) begin
                    m_mode = MODE_NUMBER;
                end else if (is_alpha(c)) begin
                    m_mode      = MODE_IDENT;
                    n_prefix[0] = c;
                end else begin
                    m_plen = '0;
                end
            end
        end

        // Keyword compare inputs after this byte's prefix write
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            pfx_nxt[i] = n_prefix[i];
        end
        len_mid = (m_plen <= LENGTH_BITS'(KW_MAX_LEN)) ? m_plen[3:0] : 4'd0;

        n_mode   = m_mode;
        n_pstart = m_pstart;
        n_plen   = m_plen;
        n_off    = r_off + 1'b1;

        // Final byte: flush the pending token, append the end marker, restart
        if (i_in.is_last) begin
            s_vld[2]   = (m_mode != MODE_IDLE);
            s_start[2] = m_pstart;
            s_len[2]   = LENGTH_BITS'(1);
            case (m_mode)
                MODE_IDENT: begin
                    s_kind[2] = kw_lookup(pfx_nxt, len_mid);
                    s_len[2]  = m_plen;
                end
                MODE_NUMBER: begin
                    s_kind[2] = KIND_NUMBER;
                    s_len[2]  = m_plen;
                end
                MODE_LT:    s_kind[2] = KIND_LSS;
                MODE_GT:    s_kind[2] = KIND_GTR;
                MODE_COLON: s_kind[2] = KIND_ERROR;
                default:    s_kind[2] = KIND_IDENT;
            endcase
            s_vld[3]   = 1'b1;
            s_kind[3]  = KIND_EOF;
            s_start[3] = n_off;
            s_len[3]   = '0;
            n_mode     = MODE_IDLE;
            n_pstart   = '0;
            n_plen     = '0;
            n_off      = '0;
        end
    end

    // Pack the valid candidates into consecutive result slots
    always_comb begin
        nres = '0;
        for (int j = 0; j < RESULTS_MAX; j++) begin
            res_kind[j]  = KIND_IDENT;
            res_start[j] = '0;
            res_len[j]   = '0;
        end
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if (s_vld[s] && (nres < RES_W'(RESULTS_MAX))) begin
                res_kind[nres]  = s_kind[s];
                res_start[nres] = s_start[s];
                res_len[nres]   = s_len[s];
                nres            = nres + 1'b1;
            end
        end
    end

    // Queue: drop the head on a pop, append this byte's tokens behind the rest
    always_comb begin
        acc  = i_in.valid && i_in.ready;
        pop  = (r_cnt != '0) && o_out.ready;
        base = r_cnt - CNT_W'(pop);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            n_q_kind[i]  = pop ? r_q_kind[i+1]  : r_q_kind[i];
            n_q_start[i] = pop ? r_q_start[i+1] : r_q_start[i];
            n_q_len[i]   = pop ? r_q_len[i+1]   : r_q_len[i];
            n_q_last[i]  = pop ? r_q_last[i+1]  : r_q_last[i];
        end
        n_q_kind[QUEUE_DEPTH-1]  = r_q_kind[QUEUE_DEPTH-1];
        n_q_start[QUEUE_DEPTH-1] = r_q_start[QUEUE_DEPTH-1];
        n_q_len[QUEUE_DEPTH-1]   = r_q_len[QUEUE_DEPTH-1];
        n_q_last[QUEUE_DEPTH-1]  = r_q_last[QUEUE_DEPTH-1];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            for (int j = 0; j < RESULTS_MAX; j++) begin
                if (acc && (RES_W'(j) < nres) &&
                    (base + CNT_W'(j) == CNT_W'(i))) begin
                    n_q_kind[i]  = res_kind[j];
                    n_q_start[i] = res_start[j];
                    n_q_len[i]   = res_len[j];
                    n_q_last[i]  = (RES_W'(j + 1) == nres);
                end
            end
        end
        n_cnt = base + (acc ? CNT_W'(nres) : '0);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pstart <= '0;
            r_plen   <= '0;
            r_off    <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (acc) begin
                r_mode   <= n_mode;
                r_pstart <= n_pstart;
                r_plen   <= n_plen;
                r_off    <= n_off;
            end
        end
    end

    // Payload registers: identifier prefix and queue entries
    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                r_prefix[i] <= n_prefix[i];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q_kind[i]  <= n_q_kind[i];
            r_q_start[i] <= n_q_start[i];
            r_q_len[i]   <= n_q_len[i];
            r_q_last[i]  <= n_q_last[i];
        end
    end

    // Ports
    assign i_in.ready         = (r_cnt <= CNT_W'(QUEUE_DEPTH - RESULTS_MAX));
    assign o_out.valid        = (r_cnt != '0);
    assign o_out.token_kind   = r_q_kind[0];
    assign o_out.start_offset = r_q_start[0];
    assign o_out.token_length = r_q_len[0];
    assign o_out.last_of_run  = r_q_last[0];

endmodule

FILE: rtl/pl0ts_checker.sv
// Port-level assertions for the PL/0 token scanner, bound to the top level.
// Depends on pl0ts_pkg and pl0_token_scanner.
`timescale 1ns / 1ps

module pl0ts_checker import pl0ts_pkg::*; #(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_in_is_last,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [5:0]             i_out_kind,
    input logic [OFFSET_BITS-1:0] i_out_start,
    input logic [LENGTH_BITS-1:0] i_out_length,
    input logic                   i_out_last
);

    // Hold a stalled token transaction
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("token valid dropped while stalled");

    a_out_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_kind) && $stable(i_out_start) &&
            $stable(i_out_length) && $stable(i_out_last))
        else $error("token payload changed while stalled");

    // The final byte always produces at least the end marker next cycle
    a_last_gives_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_is_last |=> i_out_valid)
        else $error("no token after final byte");

    // End marker is zero length and closes its run
    a_end_marker_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == 6'(KIND_EOF)) |->
            (i_out_length == '0) && i_out_last)
        else $error("malformed end marker");

    // Two-character relations carry length two
    a_pair_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_kind == 6'(KIND_LEQ)) || (i_out_kind == 6'(KIND_GEQ)) ||
                        (i_out_kind == 6'(KIND_BECOMES))) |->
            (i_out_length == LENGTH_BITS'(2)))
        else $error("two-character token with wrong length");

endmodule

bind pl0_token_scanner pl0ts_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
) u_pl0ts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_is_last (i_in.is_last),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_kind   (o_out.token_kind),
    .i_out_start  (o_out.start_offset),
    .i_out_length (o_out.token_length),
    .i_out_last   (o_out.last_of_run)
);

FILE: bench/pl0_token_scanner_tb.sv
// Self-checking bench for pl0_token_scanner: streams PL/0 source bytes, predicts tokens.
// Depends on pl0ts_pkg, pl0ts_in_if, pl0ts_out_if and the scanner RTL.
`timescale 1ns / 1ps

module pl0_token_scanner_tb;
    import pl0ts_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_BYTES = 16;
    localparam int HOLD_CYCLES  = 150;
    localparam int WORD_CHARS   = 9;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [7:0]  len;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } src_byte_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pl0ts_in_if  in_ch ();
    pl0ts_out_if out_ch ();

    pl0_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Stimulus and expected tokens
    src_byte_t byte_queue[$];
    token_t    token_queue[$];
    token_t    step_toks[$];

    // Scanner state as the bench sees it
    t_mode       lex_mode = MODE_IDLE;
    logic [31:0] tok_start = '0;
    logic [7:0]  tok_len = '0;
    logic [31:0] next_offset = '0;
    logic [7:0]  name_head[WORD_CHARS];

    string sym_chars = ";,()*/+-=#?!.";
    string kw_names[11] = '{"begin", "call", "const", "do", "end", "if", "odd",
                            "procedure", "then", "var", "while"};

    int        err_count = 0;
    int        cycle_count = 0;
    int        bytes_taken = 0;
    int        hold_left = 0;
    bit        hold_used = 1'b0;
    src_byte_t drv_item;
    token_t    mon_want;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic bit is_num_char(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    // Match the held word against the keyword list; long words stay identifiers
    function automatic t_kind classify_word();
        bit match;
        if (tok_len > WORD_CHARS) return KIND_IDENT;
        for (int k = 0; k < 11; k++) begin
            if (kw_names[k].len() == int'(tok_len)) begin
                match = 1'b1;
                for (int i = 0; i < int'(tok_len); i++) begin
                    if (8'(kw_names[k][i]) != name_head[i]) match = 1'b0;
                end
                if (match) return t_kind'(KIND_BEGIN + k);
            end
        end
        return KIND_IDENT;
    endfunction

    task automatic emit_token(input t_kind k, input logic [31:0] s, input logic [7:0] l);
        token_t t;
        t.kind  = k;
        t.start = s;
        t.len   = l;
        t.last  = 1'b0;
        if (step_toks.size() < 3) step_toks.push_back(t);
    endtask

    // Emit whatever token is held and return to idle
    task automatic flush_held();
        case (lex_mode)
            MODE_IDENT:  emit_token(classify_word(), tok_start, tok_len);
            MODE_NUMBER: emit_token(KIND_NUMBER, tok_start, tok_len);
            MODE_LT:     emit_token(KIND_LSS, tok_start, 8'd1);
            MODE_GT:     emit_token(KIND_GTR, tok_start, 8'd1);
            MODE_COLON:  emit_token(KIND_ERROR, tok_start, 8'd1);
            default: ;
        endcase
        lex_mode = MODE_IDLE;
    endtask

    // Begin a token at the current offset, or emit a single symbol at once
    task automatic open_token(input logic [7:0] c);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < 13; i++) begin
            if (!hit && 8'(sym_chars[i]) == c) begin
                emit_token(t_kind'(KIND_SEMI + i), next_offset, 8'd1);
                hit = 1'b1;
            end
        end
        if (!hit) begin
            tok_start = next_offset;
            tok_len   = 8'd1;
            if (c == CH_LT) lex_mode = MODE_LT;
            else if (c == CH_GT) lex_mode = MODE_GT;
            else if (c == CH_COLON) lex_mode = MODE_COLON;
            else if (is_num_char(c)) lex_mode = MODE_NUMBER;
            else if (is_letter(c)) begin
                lex_mode     = MODE_IDENT;
                name_head[0] = c;
            end else begin
                lex_mode = MODE_IDLE;
                tok_len  = '0;
            end
        end
    endtask

    // Advance the scanner by one accepted byte and queue the tokens it yields
    task automatic scan_byte(input logic [7:0] c, input logic last);
        step_toks.delete();
        case (lex_mode)
            MODE_IDENT: begin
                if (is_letter(c) || is_num_char(c)) begin
                    if (tok_len < WORD_CHARS) name_head[tok_len] = c;
                    if (tok_len != 8'hFF) tok_len++;
                end else begin
                    flush_held();
                    open_token(c);
                end
            end
            MODE_NUMBER: begin
                if (is_num_char(c)) begin
                    if (tok_len != 8'hFF) tok_len++;
                end else begin
                    flush_held();
                    open_token(c);
                end
            end
            MODE_LT, MODE_GT, MODE_COLON: begin
                if (c == CH_EQ) begin
                    if (lex_mode == MODE_LT) emit_token(KIND_LEQ, tok_start, 8'd2);
                    else if (lex_mode == MODE_GT) emit_token(KIND_GEQ, tok_start, 8'd2);
                    else emit_token(KIND_BECOMES, tok_start, 8'd2);
                    lex_mode = MODE_IDLE;
                end else begin
                    flush_held();
                    open_token(c);
                end
            end
            default: open_token(c);
        endcase
        next_offset = next_offset + 32'd1;
        if (last) begin
            flush_held();
            emit_token(KIND_EOF, next_offset, 8'd0);
            tok_start   = '0;
            tok_len     = '0;
            next_offset = '0;
        end
        if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
        foreach (step_toks[i]) token_queue.push_back(step_toks[i]);
    endtask

    // Stimulus helpers
    task automatic push_byte(input logic [7:0] c);
        src_byte_t b;
        b.code = c;
        b.last = 1'b0;
        byte_queue.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(8'(s[i]));
    endtask

    task automatic mark_last();
        byte_queue[byte_queue.size()-1].last = 1'b1;
    endtask

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(1) == 0) return 8'("a" + $urandom_range(25));
        return 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_alnum();
        if ($urandom_range(2) == 0) return 8'("0" + $urandom_range(9));
        return pick_letter();
    endfunction

    // Append one random lexeme; mostly well-formed, some noise
    task automatic push_lexeme();
        int k;
        int n;
        k = $urandom_range(10);
        n = $urandom_range(3);
        case (k)
            0: push_text(kw_names[$urandom_range(10)]);
            1: begin
                // keyword variants: extended, truncated, capitalized
                k = $urandom_range(10);
                if (n == 0) begin
                    push_text(kw_names[k]);
                    push_byte(pick_alnum());
                end else if (n == 1) begin
                    for (int i = 0; i < kw_names[k].len() - 1; i++)
                        push_byte(8'(kw_names[k][i]));
                end else begin
                    push_byte(8'(kw_names[k][0]) - 8'd32);
                    for (int i = 1; i < kw_names[k].len(); i++)
                        push_byte(8'(kw_names[k][i]));
                end
            end
            2, 3: begin
                push_byte(pick_letter());
                n = $urandom_range(11);
                repeat (n) push_byte(pick_alnum());
            end
            4: begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(8'("0" + $urandom_range(9)));
            end
            5, 6: push_byte(8'(sym_chars[$urandom_range(12)]));
            7: begin
                if (n == 0) push_byte(CH_LT);
                else if (n == 1) push_byte(CH_GT);
                else push_byte(CH_COLON);
                if ($urandom_range(1) == 0) push_byte(CH_EQ);
            end
            8, 9: begin
                n = $urandom_range(1, 3);
                repeat (n) push_byte($urandom_range(2) == 0 ? 8'h0A : 8'h20);
            end
            default: push_byte(8'($urandom_range(255)));
        endcase
    endtask

    function automatic bit sometimes_idle();
        if (bytes_taken >= 20 && bytes_taken < 140) return 1'b0;
        return $urandom_range(99) < 28;
    endfunction

    // Source driver: offer the next queued byte when the slot is free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                scan_byte(in_ch.char_code, in_ch.is_last);
                bytes_taken <= bytes_taken + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (byte_queue.size() > 0 && (hold_left != 0 || !sometimes_idle())) begin
                    drv_item = byte_queue.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.char_code <= drv_item.code;
                    in_ch.is_last   <= drv_item.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Hold off the token sink once, while symbol bytes stream in, to fill the scanner
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && bytes_taken >= 4) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Token monitor: compare each transaction with the oldest expected token
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (token_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected token kind %0d start %0d len %0d",
                        out_ch.token_kind, out_ch.start_offset, out_ch.token_length));
                end else begin
                    mon_want = token_queue.pop_front();
                    if (out_ch.token_kind !== mon_want.kind)
                        report_mismatch($sformatf("kind got %0d want %0d",
                            out_ch.token_kind, mon_want.kind));
                    if (out_ch.start_offset !== mon_want.start)
                        report_mismatch($sformatf("start got %0d want %0d",
                            out_ch.start_offset, mon_want.start));
                    if (out_ch.token_length !== mon_want.len)
                        report_mismatch($sformatf("length got %0d want %0d",
                            out_ch.token_length, mon_want.len));
                    if (out_ch.last_of_run !== mon_want.last)
                        report_mismatch($sformatf("last_of_run got %0b want %0b",
                            out_ch.last_of_run, mon_want.last));
                end
            end
            out_ch.ready <= (hold_left == 0) && !sometimes_idle();
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int base;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.char_code = '0;
        in_ch.is_last   = 1'b0;
        out_ch.ready    = 1'b0;
        for (int i = 0; i < WORD_CHARS; i++) name_head[i] = '0;

        // Directed: every symbol and pair, lone colon, byte extremes,
        // pending token cut by the last byte, longest keyword
        push_text("x1:=<=>=;,()*/+-=#?!.:");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(CH_LT);
        mark_last();
        push_text("procedure");
        mark_last();

        // Saturating identifier length: one byte past the top of the range
        push_byte("Z");
        repeat (255) push_byte(pick_alnum());
        mark_last();

        // Random sources of mostly well-formed lexemes
        base = byte_queue.size();
        while (byte_queue.size() - base < RANDOM_BYTES) begin
            repeat ($urandom_range(1, 6)) push_lexeme();
            mark_last();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then allow the output queue to settle
        while (byte_queue.size() != 0 || in_ch.valid || token_queue.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (token_queue.size() != 0)
            report_mismatch($sformatf("%0d tokens never arrived", token_queue.size()));

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/pl0ts_pkg.sv
rtl/pl0ts_in_if.sv
rtl/pl0ts_out_if.sv
rtl/pl0_token_scanner.sv
rtl/pl0ts_checker.sv
bench/pl0_token_scanner_tb.sv
